@@ rtl/core/tcst_pkg.sv @@
// Package for the touch contact slot tracker: sizes, codes and the structs
// passed between the controller and the slot cells. No dependencies.
package tcst_pkg;

  localparam int MAX_SLOTS = 10;
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_W = 4;

  // Touch phase flag codes; any other value is dropped.
  localparam logic [2:0] FLAGS_DOWN = 3'd2;
  localparam logic [2:0] FLAGS_MOVE = 3'd1;
  localparam logic [2:0] FLAGS_UP = 3'd4;

  typedef enum logic [1:0] {
    CMD_TOUCH = 2'd0,
    CMD_PRESS = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_BEGAN = 2'd0,
    PH_MOVED = 2'd1,
    PH_ENDED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // Search token that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic valid;
    logic [31:0] id;
    logic found;
    logic [IDX_W-1:0] idx;
    logic have_free;
    logic [IDX_W-1:0] free_idx;
  } probe_t;

  // Write command broadcast to all cells; only the addressed cell acts.
  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] idx;
    logic wr_id;
    logic wr_last;
    logic wr_start;
    logic set_act;
    logic clr_act;
    logic [31:0] id;
    logic [31:0] pt;
  } upd_t;

  // State that a cell shows to the controller.
  typedef struct packed {
    logic active;
    logic [31:0] start;
    logic [31:0] last;
  } cell_stat_t;

endpackage

@@ rtl/core/tcst_ifs.sv @@
// Channel interfaces of the touch contact slot tracker: input items,
// result items and the configuration write channel. No dependencies.
interface tcst_in_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [2:0] touch_flags;
  logic is_primary;
  logic [31:0] contact_id;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic synthesized;
  logic left_held;

  modport source (output valid, cmd, touch_flags, is_primary, contact_id, pos_x, pos_y,
                  synthesized, left_held, input ready);
  modport sink (input valid, cmd, touch_flags, is_primary, contact_id, pos_x, pos_y,
                synthesized, left_held, output ready);
endinterface

interface tcst_out_if;
  logic valid;
  logic ready;
  logic [3:0] slot;
  logic [1:0] phase;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, slot, phase, cur_x, cur_y, start_x, start_y, input ready);
  modport sink (input valid, slot, phase, cur_x, cur_y, start_x, start_y, output ready);
endinterface

interface tcst_cfg_if;
  logic valid;
  logic ready;
  logic multitouch_enabled;

  modport source (output valid, multitouch_enabled, input ready);
  modport sink (input valid, multitouch_enabled, output ready);
endinterface

@@ rtl/core/touch_contact_slot_tracker.sv @@
// Touch contact slot tracker top level: the controller and the row of slot cells.
// Depends on tcst_pkg, the channel interfaces, tcst_cell and tcst_ctrl.
// A non-primary touch report walks the search token through all MAX_SLOTS cells before its
// slot is decided; other requests go straight to the slot write.
// One request at a time: the next is taken once the result is in the output register or a
// dropped request has ended, and not while the result waits on a full output register.
// Reset (synchronous, active high) clears the active flags, the pointer history and the result
// valid, and sets multitouch on; no clearing pass.
module touch_contact_slot_tracker (
  input logic clk,
  input logic rst,
  tcst_in_if.sink item,
  tcst_out_if.source result,
  tcst_cfg_if.sink cfg
);

  tcst_pkg::probe_t probe [tcst_pkg::MAX_SLOTS+1];
  tcst_pkg::upd_t upd;
  tcst_pkg::cell_stat_t stat [tcst_pkg::MAX_SLOTS];

  tcst_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg(cfg),
    .probe_head(probe[0]),
    .probe_tail(probe[tcst_pkg::MAX_SLOTS]),
    .upd(upd),
    .stat(stat)
  );

  // Row of slot cells; the search token passes one cell per cycle.
  for (genvar i = 0; i < tcst_pkg::MAX_SLOTS; i++) begin : g_cell
    tcst_cell u_cell (
      .clk(clk),
      .rst(rst),
      .slot_idx(tcst_pkg::IDX_W'(i)),
      .probe_in(probe[i]),
      .probe_out(probe[i+1]),
      .upd(upd),
      .stat(stat[i])
    );
  end

endmodule

@@ rtl/core/tcst_cell.sv @@
// One contact slot cell: holds the slot state, takes part in the id search
// and applies broadcast writes. Depends on tcst_pkg.
module tcst_cell (
  input  logic clk,
  input  logic rst,
  input  logic [tcst_pkg::IDX_W-1:0] slot_idx,
  input  tcst_pkg::probe_t probe_in,
  output tcst_pkg::probe_t probe_out,
  input  tcst_pkg::upd_t upd,
  output tcst_pkg::cell_stat_t stat
);

  logic active;
  logic [31:0] contact;
  logic [31:0] start_xy;
  logic [31:0] last_xy;
  tcst_pkg::probe_t probe_next;
  logic hit;

  // Search step: slot 0 is reserved for the primary contact and only passes.
  always_comb begin
    probe_next = probe_in;
    if (probe_in.valid && (slot_idx != '0) && !probe_in.found) begin
      if (active && (contact == probe_in.id)) begin
        probe_next.found = 1'b1;
        probe_next.idx = slot_idx;
      end else if (!active && !probe_in.have_free) begin
        probe_next.have_free = 1'b1;
        probe_next.free_idx = slot_idx;
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  assign hit = upd.we && (upd.idx == slot_idx);

  // Active flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (hit) begin
      if (upd.set_act) begin
        active <= 1'b1;
      end else if (upd.clr_act) begin
        active <= 1'b0;
      end
    end
  end

  // Slot payload, undefined until first written.
  always_ff @(posedge clk) begin
    if (hit) begin
      if (upd.wr_id) begin
        contact <= upd.id;
      end
      if (upd.wr_start) begin
        start_xy <= upd.pt;
      end
      if (upd.wr_last) begin
        last_xy <= upd.pt;
      end
    end
  end

  assign stat.active = active;
  assign stat.start = start_xy;
  assign stat.last = last_xy;

endmodule

@@ rtl/core/tcst_ctrl.sv @@
// Controller of the touch contact slot tracker: takes requests, injects the
// search token, decides the slot write and drives the result register.
// Depends on tcst_pkg and the channel interfaces.
module tcst_ctrl (
  input  logic clk,
  input  logic rst,
  tcst_in_if.sink item,
  tcst_out_if.source result,
  tcst_cfg_if.sink cfg,
  output tcst_pkg::probe_t probe_head,
  input  tcst_pkg::probe_t probe_tail,
  output tcst_pkg::upd_t upd,
  input  tcst_pkg::cell_stat_t stat [tcst_pkg::MAX_SLOTS]
);

  tcst_pkg::state_t state;
  tcst_pkg::state_t state_next;

  tcst_pkg::cmd_t cmd_q;
  logic [2:0] flags_q;
  logic [31:0] id_q;
  logic [31:0] pt_q;
  logic synth_q;
  logic held_q;
  logic found_q;
  logic [tcst_pkg::IDX_W-1:0] idx_q;
  tcst_pkg::phase_t phase_q;
  tcst_pkg::phase_t phase_next;
  logic multitouch;
  logic ptr_seen;
  logic [31:0] ptr_last;

  logic accept;
  logic need_scan;
  logic take_tail;
  logic ptr_wr;
  logic out_free;
  logic load_out;
  logic emit;
  logic ph_ok;
  tcst_pkg::phase_t ph_dec;
  tcst_pkg::cell_stat_t sel;

  assign accept = item.valid && item.ready;
  assign need_scan = (tcst_pkg::cmd_t'(item.cmd) == tcst_pkg::CMD_TOUCH) && !item.is_primary;
  assign out_free = !result.valid || result.ready;
  assign sel = stat[idx_q];
  assign item.ready = (state == tcst_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;

  // Search token enters the first cell in the cycle of the request.
  always_comb begin
    probe_head = '0;
    probe_head.valid = accept && need_scan;
    probe_head.id = item.contact_id;
  end

  // Touch phase decode from the exact flag value.
  always_comb begin
    ph_ok = 1'b1;
    ph_dec = tcst_pkg::PH_BEGAN;
    case (flags_q)
      tcst_pkg::FLAGS_DOWN: ph_dec = tcst_pkg::PH_BEGAN;
      tcst_pkg::FLAGS_MOVE: ph_dec = tcst_pkg::PH_MOVED;
      tcst_pkg::FLAGS_UP: ph_dec = tcst_pkg::PH_ENDED;
      default: ph_ok = 1'b0;
    endcase
  end

  // Next state, slot write and event decision.
  always_comb begin
    state_next = state;
    take_tail = 1'b0;
    ptr_wr = 1'b0;
    load_out = 1'b0;
    emit = 1'b0;
    phase_next = phase_q;
    upd = '0;
    upd.idx = idx_q;
    upd.id = id_q;
    upd.pt = pt_q;
    case (state)
      tcst_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = need_scan ? tcst_pkg::ST_SCAN : tcst_pkg::ST_EXEC;
        end
      end
      tcst_pkg::ST_SCAN: begin
        if (probe_tail.valid) begin
          take_tail = 1'b1;
          state_next = tcst_pkg::ST_EXEC;
        end
      end
      tcst_pkg::ST_EXEC: begin
        case (cmd_q)
          tcst_pkg::CMD_TOUCH: begin
            if (ph_ok && found_q) begin
              upd.we = 1'b1;
              upd.wr_id = 1'b1;
              upd.wr_last = 1'b1;
              phase_next = ph_dec;
              case (ph_dec)
                tcst_pkg::PH_BEGAN: begin
                  emit = 1'b1;
                  if (sel.active) begin
                    phase_next = tcst_pkg::PH_MOVED;
                  end else begin
                    upd.set_act = 1'b1;
                    upd.wr_start = 1'b1;
                  end
                end
                tcst_pkg::PH_MOVED: emit = sel.active;
                default: begin
                  emit = sel.active;
                  upd.clr_act = sel.active;
                end
              endcase
            end
          end
          tcst_pkg::CMD_PRESS: begin
            if (!sel.active && !synth_q) begin
              upd.we = 1'b1;
              upd.set_act = 1'b1;
              upd.wr_start = 1'b1;
              upd.wr_last = 1'b1;
              emit = 1'b1;
              phase_next = tcst_pkg::PH_BEGAN;
            end
          end
          tcst_pkg::CMD_MOVE: begin
            if (!(ptr_seen && (ptr_last == pt_q))) begin
              ptr_wr = 1'b1;
              if (sel.active && !synth_q && held_q) begin
                upd.we = 1'b1;
                upd.wr_last = 1'b1;
                emit = 1'b1;
                phase_next = tcst_pkg::PH_MOVED;
              end
            end
          end
          default: begin
            if (sel.active && !synth_q) begin
              upd.we = 1'b1;
              upd.clr_act = 1'b1;
              upd.wr_last = 1'b1;
              emit = 1'b1;
              phase_next = tcst_pkg::PH_ENDED;
            end
          end
        endcase
        // With multitouch off only slot 0 reports.
        if (emit && ((idx_q == '0) || multitouch)) begin
          state_next = tcst_pkg::ST_EMIT;
        end else begin
          state_next = tcst_pkg::ST_IDLE;
        end
      end
      tcst_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_next = tcst_pkg::ST_IDLE;
        end
      end
      default: state_next = tcst_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: configuration, pointer history, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      multitouch <= 1'b1;
      ptr_seen <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        multitouch <= cfg.multitouch_enabled;
      end
      if (ptr_wr) begin
        ptr_seen <= 1'b1;
      end
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Request payload and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= tcst_pkg::cmd_t'(item.cmd);
      flags_q <= item.touch_flags;
      id_q <= item.contact_id;
      pt_q <= {item.pos_y, item.pos_x};
      synth_q <= item.synthesized;
      held_q <= item.left_held;
      found_q <= 1'b1;
      idx_q <= '0;
    end else if (take_tail) begin
      found_q <= probe_tail.found || probe_tail.have_free;
      idx_q <= probe_tail.found ? probe_tail.idx : probe_tail.free_idx;
    end
    if (ptr_wr) begin
      ptr_last <= pt_q;
    end
    phase_q <= phase_next;
  end

  // Result register, loaded from the slot after its write has landed.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result.slot <= tcst_pkg::SLOT_W'(idx_q);
      result.phase <= phase_q;
      result.cur_x <= sel.last[15:0];
      result.cur_y <= sel.last[31:16];
      result.start_x <= sel.start[15:0];
      result.start_y <= sel.start[31:16];
    end
  end

`ifndef SYNTHESIS
  // The search token leaves the chain only while the controller waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    probe_tail.valid |-> state == tcst_pkg::ST_SCAN)
    else $error("search token left the chain outside of a scan");

  // A touch report with no slot found ends without an event.
  a_no_slot_drop: assert property (@(posedge clk) disable iff (rst)
    (state == tcst_pkg::ST_EXEC && cmd_q == tcst_pkg::CMD_TOUCH && !found_q)
    |=> state == tcst_pkg::ST_IDLE)
    else $error("touch report without a slot did not drop");

  // A loaded result names the slot that was worked on.
  a_slot_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == tcst_pkg::ST_EMIT && out_free)
    |=> result.valid && result.slot == tcst_pkg::SLOT_W'($past(idx_q)))
    else $error("result slot does not match the worked slot");

  // A began event starts where it currently is.
  a_began_at_start: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.phase == tcst_pkg::PH_BEGAN)
    |-> (result.cur_x == result.start_x && result.cur_y == result.start_y))
    else $error("began event with current point off its start point");
`endif

endmodule
